// ===== design/pkt_pkg.sv =====
// ----------------------------------------------------------------------------
// pkt_pkg
// Shared types, codes and sizes of the packed keyed table.
// ----------------------------------------------------------------------------
package pkt_pkg;

    // table sizing
    localparam int TABLE_DEPTH  = 512;
    localparam int KEY_BYTES    = 8;
    localparam int PAYLOAD_BITS = 32;

    // fixed field widths of the stream beats
    localparam int OP_W     = 3;
    localparam int KEY_W    = 64;
    localparam int INDEX_W  = 9;
    localparam int PAY_W    = 32;
    localparam int STATUS_W = 2;
    localparam int LCOUNT_W = 10;

    // derived storage widths
    localparam int IDX_W   = $clog2(TABLE_DEPTH);
    localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
    localparam int CMP_W   = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;
    localparam int KEY_SW  = 8 * KEY_BYTES;
    localparam int PAY_SW  = (PAYLOAD_BITS < PAY_W) ? PAYLOAD_BITS : PAY_W;

    // stream data widths, padded to whole bytes
    localparam int S_FIELDS_W = OP_W + KEY_W + INDEX_W + PAY_W;
    localparam int M_FIELDS_W = STATUS_W + INDEX_W + KEY_W + PAY_W + LCOUNT_W;
    localparam int S_DATA_W   = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_DATA_W   = ((M_FIELDS_W + 7) / 8) * 8;

    // operation codes
    localparam logic [OP_W-1:0] OP_INSERT   = 3'd0;
    localparam logic [OP_W-1:0] OP_DEL_KEY  = 3'd1;
    localparam logic [OP_W-1:0] OP_DEL_IDX  = 3'd2;
    localparam logic [OP_W-1:0] OP_FIND_KEY = 3'd3;
    localparam logic [OP_W-1:0] OP_READ_IDX = 3'd4;

    // result status codes
    localparam logic [STATUS_W-1:0] STAT_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_MISS = 2'd2;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_INSERT,
        S_WALK,
        S_APPLY,
        S_RESP
    } state_t;

    // one stored entry
    typedef struct packed {
        logic [KEY_SW-1:0] key;
        logic [PAY_SW-1:0] pay;
    } entry_t;

    // lowest-hit token passed up the chain
    typedef struct packed {
        logic              hit;
        logic [IDX_W-1:0]  idx;
        logic [KEY_SW-1:0] key;
        logic [PAY_SW-1:0] pay;
    } carry_t;

    // broadcast control from the sequencer to every cell
    typedef struct packed {
        logic              wr_en;
        logic              shift_en;
        logic [IDX_W-1:0]  shift_pos;
        logic              mode_key;
        logic              idx_ok;
        logic [KEY_SW-1:0] query_key;
        logic [IDX_W-1:0]  query_idx;
        logic [PAY_SW-1:0] query_pay;
        logic [CNT_W-1:0]  count;
    } cell_ctrl_t;

endpackage

// ===== design/pkt_cell.sv =====
// ----------------------------------------------------------------------------
// pkt_cell
// One table position: holds an entry, takes the upper neighbor's entry on a
// compaction, and forwards the lowest-hit token one position per cycle.
// ----------------------------------------------------------------------------
module pkt_cell (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic [pkt_pkg::IDX_W-1:0] cell_idx,
    input  pkt_pkg::cell_ctrl_t       ctrl,
    input  pkt_pkg::entry_t           upper_entry,
    output pkt_pkg::entry_t           entry,
    input  pkt_pkg::carry_t           carry_in,
    output pkt_pkg::carry_t           carry_out
);
    import pkt_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;
    carry_t carry_reg;
    carry_t carry_next;
    logic   live;
    logic   match;

    // hit test against the broadcast query
    always_comb begin
        live  = CNT_W'(cell_idx) < ctrl.count;
        match = live && (ctrl.mode_key ? (entry_reg.key == ctrl.query_key)
                                       : (ctrl.idx_ok && (cell_idx == ctrl.query_idx)));
    end

    // keep a lower hit, otherwise offer our own entry
    always_comb begin
        carry_next = carry_in;
        if (!carry_in.hit && match) begin
            carry_next.hit = 1'b1;
            carry_next.idx = cell_idx;
            carry_next.key = entry_reg.key;
            carry_next.pay = entry_reg.pay;
        end
    end

    // append on insert, close the gap on delete
    always_comb begin
        entry_next = entry_reg;
        if (ctrl.wr_en && (CNT_W'(cell_idx) == ctrl.count)) begin
            entry_next.key = ctrl.query_key;
            entry_next.pay = ctrl.query_pay;
        end else if (ctrl.shift_en && (cell_idx >= ctrl.shift_pos)) begin
            entry_next = upper_entry;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            carry_reg <= '0;
        end else begin
            carry_reg <= carry_next;
        end
    end

    assign entry     = entry_reg;
    assign carry_out = carry_reg;

endmodule

// ===== design/pkt_ctrl.sv =====
// ----------------------------------------------------------------------------
// pkt_ctrl
// Operation sequencer: takes a request beat, drives the cell row through an
// append or a walk and an update, keeps the live count and holds the result beat.
// ----------------------------------------------------------------------------
module pkt_ctrl (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [pkt_pkg::OP_W-1:0]      in_op,
    input  logic [pkt_pkg::KEY_W-1:0]     in_key,
    input  logic [pkt_pkg::INDEX_W-1:0]   in_idx,
    input  logic [pkt_pkg::PAY_W-1:0]     in_pay,
    input  pkt_pkg::carry_t               last_carry,
    output pkt_pkg::cell_ctrl_t           cell_ctrl,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [pkt_pkg::STATUS_W-1:0]  out_status,
    output logic [pkt_pkg::INDEX_W-1:0]   out_idx,
    output logic [pkt_pkg::KEY_W-1:0]     out_key,
    output logic [pkt_pkg::PAY_W-1:0]     out_pay,
    output logic [pkt_pkg::LCOUNT_W-1:0]  out_count
);
    import pkt_pkg::*;

    state_t              state_reg, state_next;
    logic [IDX_W-1:0]    walk_reg, walk_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [OP_W-1:0]     op_reg, op_next;
    logic [KEY_SW-1:0]   qkey_reg, qkey_next;
    logic [IDX_W-1:0]    qidx_reg, qidx_next;
    logic [PAY_SW-1:0]   qpay_reg, qpay_next;
    logic                idx_ok_reg, idx_ok_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [INDEX_W-1:0]  res_idx_reg, res_idx_next;
    logic [KEY_W-1:0]    res_key_reg, res_key_next;
    logic [PAY_W-1:0]    res_pay_reg, res_pay_next;
    logic                m_valid_reg, m_valid_next;
    logic [STATUS_W-1:0] m_status_reg, m_status_next;
    logic [INDEX_W-1:0]  m_idx_reg, m_idx_next;
    logic [KEY_W-1:0]    m_key_reg, m_key_next;
    logic [PAY_W-1:0]    m_pay_reg, m_pay_next;
    logic [LCOUNT_W-1:0] m_count_reg, m_count_next;

    logic accept;
    logic full;
    logic is_delete;
    logic out_load;

    assign full      = count_reg >= CNT_W'(TABLE_DEPTH);
    assign is_delete = (op_reg == OP_DEL_KEY) || (op_reg == OP_DEL_IDX);
    assign accept    = in_valid && in_ready;
    assign out_load  = (state_reg == S_RESP) && (!m_valid_reg || out_ready);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    if (in_op == OP_INSERT) begin
                        state_next = S_INSERT;
                    end else if ((in_op == OP_DEL_KEY) || (in_op == OP_FIND_KEY) ||
                                 (in_op == OP_DEL_IDX) || (in_op == OP_READ_IDX)) begin
                        state_next = S_WALK;
                    end else begin
                        state_next = S_RESP;
                    end
                end
            end
            S_INSERT: state_next = S_RESP;
            S_WALK: begin
                if (walk_reg == IDX_W'(TABLE_DEPTH - 1)) begin
                    state_next = S_APPLY;
                end
            end
            S_APPLY: state_next = S_RESP;
            S_RESP: begin
                if (out_load) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // outputs toward the request side and the cell row
    always_comb begin
        in_ready           = 1'b0;
        cell_ctrl          = '0;
        cell_ctrl.mode_key = (op_reg == OP_DEL_KEY) || (op_reg == OP_FIND_KEY);
        cell_ctrl.idx_ok   = idx_ok_reg;
        cell_ctrl.query_key = qkey_reg;
        cell_ctrl.query_idx = qidx_reg;
        cell_ctrl.query_pay = qpay_reg;
        cell_ctrl.count     = count_reg;
        unique case (state_reg)
            S_IDLE:   in_ready = 1'b1;
            S_INSERT: cell_ctrl.wr_en = !full;
            S_APPLY: begin
                cell_ctrl.shift_en  = last_carry.hit && is_delete;
                cell_ctrl.shift_pos = last_carry.idx;
            end
            S_WALK, S_RESP: ;
            default: ;
        endcase
    end

    // datapath registers
    always_comb begin
        walk_next       = walk_reg;
        count_next      = count_reg;
        op_next         = op_reg;
        qkey_next       = qkey_reg;
        qidx_next       = qidx_reg;
        qpay_next       = qpay_reg;
        idx_ok_next     = idx_ok_reg;
        res_status_next = res_status_reg;
        res_idx_next    = res_idx_reg;
        res_key_next    = res_key_reg;
        res_pay_next    = res_pay_reg;
        m_valid_next    = m_valid_reg;
        m_status_next   = m_status_reg;
        m_idx_next      = m_idx_reg;
        m_key_next      = m_key_reg;
        m_pay_next      = m_pay_reg;
        m_count_next    = m_count_reg;

        // latch the request and default to a miss
        if (accept) begin
            op_next         = in_op;
            qkey_next       = in_key[KEY_SW-1:0];
            qidx_next       = IDX_W'(in_idx);
            qpay_next       = in_pay[PAY_SW-1:0];
            idx_ok_next     = CMP_W'(in_idx) < CMP_W'(count_reg);
            walk_next       = '0;
            res_status_next = STAT_MISS;
            res_idx_next    = '0;
            res_key_next    = '0;
            res_pay_next    = '0;
        end

        // append or report full
        if (state_reg == S_INSERT) begin
            if (full) begin
                res_status_next = STAT_FULL;
            end else begin
                res_status_next = STAT_OK;
                count_next      = count_reg + CNT_W'(1);
            end
        end

        if (state_reg == S_WALK) begin
            walk_next = walk_reg + IDX_W'(1);
        end

        // take the lowest hit from the top of the chain
        if ((state_reg == S_APPLY) && last_carry.hit) begin
            res_status_next = STAT_OK;
            res_idx_next    = INDEX_W'(last_carry.idx);
            res_key_next    = KEY_W'(last_carry.key);
            res_pay_next    = PAY_W'(last_carry.pay);
            if (is_delete) begin
                count_next = count_reg - CNT_W'(1);
            end
        end

        // result beat register
        if (out_load) begin
            m_valid_next  = 1'b1;
            m_status_next = res_status_reg;
            m_idx_next    = res_idx_reg;
            m_key_next    = res_key_reg;
            m_pay_next    = res_pay_reg;
            m_count_next  = LCOUNT_W'(count_reg);
        end else if (out_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        walk_reg       <= walk_next;
        op_reg         <= op_next;
        qkey_reg       <= qkey_next;
        qidx_reg       <= qidx_next;
        qpay_reg       <= qpay_next;
        idx_ok_reg     <= idx_ok_next;
        res_status_reg <= res_status_next;
        res_idx_reg    <= res_idx_next;
        res_key_reg    <= res_key_next;
        res_pay_reg    <= res_pay_next;
        m_status_reg   <= m_status_next;
        m_idx_reg      <= m_idx_next;
        m_key_reg      <= m_key_next;
        m_pay_reg      <= m_pay_next;
        m_count_reg    <= m_count_next;
    end

    assign out_valid  = m_valid_reg;
    assign out_status = m_status_reg;
    assign out_idx    = m_idx_reg;
    assign out_key    = m_key_reg;
    assign out_pay    = m_pay_reg;
    assign out_count  = m_count_reg;

endmodule

// ===== design/packed_keyed_table.sv =====
// ----------------------------------------------------------------------------
// packed_keyed_table
// Packed key/payload table with insert, delete, find and read, built as a
// row of entry cells with a lowest-hit token running up the row.
// ----------------------------------------------------------------------------
// sequencing: insert passes through an append state and unknown operations go
//   straight to the result beat; key and index operations first walk the hit
//   token one cell per cycle through all TABLE_DEPTH cells, then apply the update
// throughput: one operation at a time; a new request beat is taken as soon as
//   the previous result is parked in the output register
// reset: aresetn clears the live count, sequencer and output valid; entry
//   contents are not cleared
module packed_keyed_table (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // operation, entry_key, entry_index, entry_payload, zero pad
    input  logic [pkt_pkg::S_DATA_W-1:0] s_tdata,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // status, found_index, found_key, found_payload, live_count, zero pad
    output logic [pkt_pkg::M_DATA_W-1:0] m_tdata
);
    import pkt_pkg::*;

    logic [OP_W-1:0]     s_operation;
    logic [KEY_W-1:0]    s_entry_key;
    logic [INDEX_W-1:0]  s_entry_index;
    logic [PAY_W-1:0]    s_entry_payload;
    logic [STATUS_W-1:0] m_status;
    logic [INDEX_W-1:0]  m_found_index;
    logic [KEY_W-1:0]    m_found_key;
    logic [PAY_W-1:0]    m_found_payload;
    logic [LCOUNT_W-1:0] m_live_count;

    cell_ctrl_t cell_ctrl;
    entry_t     ent_w   [TABLE_DEPTH];
    carry_t     carry_w [TABLE_DEPTH];

    // unpack the request beat
    assign s_operation     = s_tdata[OP_W-1:0];
    assign s_entry_key     = s_tdata[OP_W +: KEY_W];
    assign s_entry_index   = s_tdata[OP_W + KEY_W +: INDEX_W];
    assign s_entry_payload = s_tdata[OP_W + KEY_W + INDEX_W +: PAY_W];

    pkt_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_op      (s_operation),
        .in_key     (s_entry_key),
        .in_idx     (s_entry_index),
        .in_pay     (s_entry_payload),
        .last_carry (carry_w[TABLE_DEPTH-1]),
        .cell_ctrl  (cell_ctrl),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_status (m_status),
        .out_idx    (m_found_index),
        .out_key    (m_found_key),
        .out_pay    (m_found_payload),
        .out_count  (m_live_count)
    );

    // row of cells, token enters at position zero
    for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
        entry_t upper;
        carry_t lower;

        if (i == TABLE_DEPTH - 1) begin : g_top
            assign upper = '0;
        end else begin : g_mid
            assign upper = ent_w[i+1];
        end

        if (i == 0) begin : g_first
            assign lower = '0;
        end else begin : g_next
            assign lower = carry_w[i-1];
        end

        pkt_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .cell_idx    (IDX_W'(i)),
            .ctrl        (cell_ctrl),
            .upper_entry (upper),
            .entry       (ent_w[i]),
            .carry_in    (lower),
            .carry_out   (carry_w[i])
        );
    end

    // pack the result beat
    assign m_tdata = M_DATA_W'({m_live_count, m_found_payload, m_found_key,
                                m_found_index, m_status});

    // live count stays within the table
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        CMP_W'(cell_ctrl.count) <= CMP_W'(TABLE_DEPTH))
        else $error("live count above table depth");

    // append and compaction never in the same cycle
    a_wr_shift_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cell_ctrl.wr_en && cell_ctrl.shift_en))
        else $error("insert and compaction together");

    // a compaction removes exactly one entry
    a_shift_count: assert property (@(posedge aclk) disable iff (!aresetn)
        cell_ctrl.shift_en |=> cell_ctrl.count == $past(cell_ctrl.count) - CNT_W'(1))
        else $error("compaction did not drop count by one");

    // a full report only when the table is full
    a_full_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_status == STAT_FULL)) |-> (m_live_count == LCOUNT_W'(TABLE_DEPTH)))
        else $error("full status with free space");

endmodule
